[src/tgc_pkg.sv]
`default_nettype none

package tgc_pkg;

    // Fixed field widths of the streams and the configuration port.
    localparam int TIME_W     = 32;
    localparam int RAW_W      = 16;
    localparam int DIST_W     = 10;
    localparam int MS_W       = 16;
    localparam int EV_W       = 4;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Input item: now_ms, int_low, touching, raw_x, raw_y, padded to whole bytes.
    localparam int IN_BITS    = TIME_W + 2 + 2 * RAW_W;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;

    localparam int DEF_SCREEN_WIDTH  = 480;
    localparam int DEF_SCREEN_HEIGHT = 800;

    typedef enum logic {
        OP_UPDATE = 1'b0,
        OP_POP    = 1'b1
    } t_op;

    typedef enum logic [EV_W-1:0] {
        EV_NONE        = 4'd0,
        EV_DOWN        = 4'd1,
        EV_MOVE        = 4'd2,
        EV_UP          = 4'd3,
        EV_CLICK       = 4'd4,
        EV_SWIPE_LEFT  = 4'd5,
        EV_SWIPE_RIGHT = 4'd6,
        EV_SWIPE_UP    = 4'd7,
        EV_SWIPE_DOWN  = 4'd8
    } t_event;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SWIPE_MIN_DISTANCE = 8'd0,
        REG_SWIPE_CROSS_LIMIT  = 8'd1,
        REG_SWIPE_MAX_MS       = 8'd2,
        REG_TAP_MAX_DISTANCE   = 8'd3,
        REG_TAP_MAX_MS         = 8'd4,
        REG_MOVE_THRESHOLD     = 8'd5,
        REG_POLL_PERIOD_MS     = 8'd6,
        REG_INT_STALE_MS       = 8'd7
    } t_reg_idx;

    localparam logic [DIST_W-1:0] RST_SWIPE_MIN_DISTANCE = 10'd70;
    localparam logic [DIST_W-1:0] RST_SWIPE_CROSS_LIMIT  = 10'd60;
    localparam logic [MS_W-1:0]   RST_SWIPE_MAX_MS       = 16'd600;
    localparam logic [DIST_W-1:0] RST_TAP_MAX_DISTANCE   = 10'd50;
    localparam logic [MS_W-1:0]   RST_TAP_MAX_MS         = 16'd1000;
    localparam logic [DIST_W-1:0] RST_MOVE_THRESHOLD     = 10'd15;
    localparam logic [MS_W-1:0]   RST_POLL_PERIOD_MS     = 16'd50;
    localparam logic [MS_W-1:0]   RST_INT_STALE_MS       = 16'd3000;

    typedef struct packed {
        logic [DIST_W-1:0] swipe_min_distance;
        logic [DIST_W-1:0] swipe_cross_limit;
        logic [MS_W-1:0]   swipe_max_ms;
        logic [DIST_W-1:0] tap_max_distance;
        logic [MS_W-1:0]   tap_max_ms;
        logic [DIST_W-1:0] move_threshold;
        logic [MS_W-1:0]   poll_period_ms;
        logic [MS_W-1:0]   int_stale_ms;
    } t_cfg;

endpackage

`default_nettype wire

[src/tgc_cfg.sv]
`default_nettype none

module tgc_cfg
    import tgc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.swipe_min_distance <= RST_SWIPE_MIN_DISTANCE;
            r_cfg.swipe_cross_limit  <= RST_SWIPE_CROSS_LIMIT;
            r_cfg.swipe_max_ms       <= RST_SWIPE_MAX_MS;
            r_cfg.tap_max_distance   <= RST_TAP_MAX_DISTANCE;
            r_cfg.tap_max_ms         <= RST_TAP_MAX_MS;
            r_cfg.move_threshold     <= RST_MOVE_THRESHOLD;
            r_cfg.poll_period_ms     <= RST_POLL_PERIOD_MS;
            r_cfg.int_stale_ms       <= RST_INT_STALE_MS;
        end else if (i_cfg_valid) begin
            // Indexes beyond the register list are dropped.
            case (i_cfg_index)
                REG_SWIPE_MIN_DISTANCE: r_cfg.swipe_min_distance <= i_cfg_data[DIST_W-1:0];
                REG_SWIPE_CROSS_LIMIT:  r_cfg.swipe_cross_limit  <= i_cfg_data[DIST_W-1:0];
                REG_SWIPE_MAX_MS:       r_cfg.swipe_max_ms       <= i_cfg_data[MS_W-1:0];
                REG_TAP_MAX_DISTANCE:   r_cfg.tap_max_distance   <= i_cfg_data[DIST_W-1:0];
                REG_TAP_MAX_MS:         r_cfg.tap_max_ms         <= i_cfg_data[MS_W-1:0];
                REG_MOVE_THRESHOLD:     r_cfg.move_threshold     <= i_cfg_data[DIST_W-1:0];
                REG_POLL_PERIOD_MS:     r_cfg.poll_period_ms     <= i_cfg_data[MS_W-1:0];
                REG_INT_STALE_MS:       r_cfg.int_stale_ms       <= i_cfg_data[MS_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[src/tgc_core.sv]
`default_nettype none

module tgc_core
    import tgc_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
    localparam int XW = $clog2(SCREEN_WIDTH),
    localparam int YW = $clog2(SCREEN_HEIGHT)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire t_op               i_op,
    input  wire logic [TIME_W-1:0] i_now,
    input  wire logic              i_int_low,
    input  wire logic              i_touching,
    input  wire logic [RAW_W-1:0]  i_raw_x,
    input  wire logic [RAW_W-1:0]  i_raw_y,
    input  wire t_cfg              i_cfg,
    output t_event                 o_event,
    output logic [XW-1:0]          o_pos_x,
    output logic [YW-1:0]          o_pos_y,
    output logic [XW-1:0]          o_origin_x,
    output logic [YW-1:0]          o_origin_y,
    output logic [TIME_W-1:0]      o_duration
);

    localparam int MW = (XW > YW) ? XW : YW;
    localparam int CW = ((MW > DIST_W) ? MW : DIST_W) + 2;
    localparam logic [RAW_W-2:0] X_MAX = (RAW_W - 1)'(SCREEN_WIDTH - 1);
    localparam logic [RAW_W-2:0] Y_MAX = (RAW_W - 1)'(SCREEN_HEIGHT - 1);

    logic              r_pressed;
    logic [XW-1:0]     r_down_x, r_last_x, r_held_x, r_held_ox;
    logic [YW-1:0]     r_down_y, r_last_y, r_held_y, r_held_oy;
    logic [TIME_W-1:0] r_down_time, r_int_time, r_poll_time, r_held_dur;
    t_event            r_held_type;

    logic [TIME_W-1:0] n_int_time, int_age, poll_age, period, dur;
    logic              gated;
    logic [XW-1:0]     cx;
    logic [YW-1:0]     cy;
    logic signed [CW-1:0] rel_dx, rel_dy, rel_adx, rel_ady;
    logic signed [CW-1:0] mov_dx, mov_dy, mov_adx, mov_ady;
    logic signed [CW-1:0] cross_lim, swipe_min, tap_max, move_th;
    logic              fast, moved;
    t_event            rel_type;

    // Poll gate: idle ticks without INT within poll period skip while INT is fresh.
    assign n_int_time = i_int_low ? i_now : r_int_time;
    assign int_age    = i_now - n_int_time;
    assign poll_age   = i_now - r_poll_time;
    assign period     = (int_age < TIME_W'(i_cfg.int_stale_ms)) ?
                        TIME_W'(i_cfg.poll_period_ms) : '0;
    assign gated      = !i_int_low && !r_pressed && (poll_age < period);

    // Clamp raw coordinates to the screen.
    always_comb begin
        if (i_raw_x[RAW_W-1])
            cx = '0;
        else if (i_raw_x[RAW_W-2:0] > X_MAX)
            cx = XW'(SCREEN_WIDTH - 1);
        else
            cx = i_raw_x[XW-1:0];
        if (i_raw_y[RAW_W-1])
            cy = '0;
        else if (i_raw_y[RAW_W-2:0] > Y_MAX)
            cy = YW'(SCREEN_HEIGHT - 1);
        else
            cy = i_raw_y[YW-1:0];
    end

    assign cross_lim = $signed(CW'(i_cfg.swipe_cross_limit));
    assign swipe_min = $signed(CW'(i_cfg.swipe_min_distance));
    assign tap_max   = $signed(CW'(i_cfg.tap_max_distance));
    assign move_th   = $signed(CW'(i_cfg.move_threshold));

    // Release classification works on the last reported point.
    assign rel_dx  = $signed(CW'(r_last_x)) - $signed(CW'(r_down_x));
    assign rel_dy  = $signed(CW'(r_last_y)) - $signed(CW'(r_down_y));
    assign rel_adx = rel_dx[CW-1] ? -rel_dx : rel_dx;
    assign rel_ady = rel_dy[CW-1] ? -rel_dy : rel_dy;
    assign dur     = i_now - r_down_time;
    assign fast    = dur < TIME_W'(i_cfg.swipe_max_ms);

    always_comb begin
        if (rel_adx > swipe_min && rel_ady < cross_lim && fast)
            rel_type = rel_dx[CW-1] ? EV_SWIPE_LEFT :
                       ((rel_dx != '0) ? EV_SWIPE_RIGHT : EV_SWIPE_LEFT);
        else if (rel_dy > cross_lim && rel_adx < cross_lim && fast)
            rel_type = EV_SWIPE_DOWN;
        else if (rel_dy < -cross_lim && rel_adx < cross_lim && fast)
            rel_type = EV_SWIPE_UP;
        else if (rel_adx < tap_max && rel_ady < tap_max &&
                 dur < TIME_W'(i_cfg.tap_max_ms))
            rel_type = EV_CLICK;
        else
            rel_type = EV_UP;
    end

    assign mov_dx  = $signed(CW'(cx)) - $signed(CW'(r_down_x));
    assign mov_dy  = $signed(CW'(cy)) - $signed(CW'(r_down_y));
    assign mov_adx = mov_dx[CW-1] ? -mov_dx : mov_dx;
    assign mov_ady = mov_dy[CW-1] ? -mov_dy : mov_dy;
    assign moved   = (mov_adx > move_th) || (mov_ady > move_th);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed   <= 1'b0;
            r_held_type <= EV_NONE;
            r_int_time  <= '0;
            r_poll_time <= '0;
        end else if (i_fire) begin
            if (i_op == OP_POP) begin
                r_held_type <= EV_NONE;
            end else begin
                r_int_time <= n_int_time;
                if (!gated) begin
                    r_poll_time <= i_now;
                    // A passing tick clears the held item unless it makes a new one.
                    if (!i_touching) begin
                        r_pressed   <= 1'b0;
                        r_held_type <= r_pressed ? rel_type : EV_NONE;
                    end else if (!r_pressed) begin
                        r_pressed   <= 1'b1;
                        r_held_type <= EV_DOWN;
                    end else begin
                        r_held_type <= moved ? EV_MOVE : EV_NONE;
                    end
                end
            end
        end
    end

    // Payload registers of the touch tracker and the held item.
    always_ff @(posedge i_clk) begin
        if (i_fire && i_op == OP_UPDATE && !gated) begin
            if (!i_touching) begin
                if (r_pressed) begin
                    r_held_x   <= r_last_x;
                    r_held_y   <= r_last_y;
                    r_held_ox  <= r_down_x;
                    r_held_oy  <= r_down_y;
                    r_held_dur <= dur;
                end
            end else begin
                r_last_x <= cx;
                r_last_y <= cy;
                if (!r_pressed) begin
                    r_down_x    <= cx;
                    r_down_y    <= cy;
                    r_down_time <= i_now;
                    r_held_x    <= cx;
                    r_held_y    <= cy;
                    r_held_ox   <= cx;
                    r_held_oy   <= cy;
                    r_held_dur  <= '0;
                end else if (moved) begin
                    r_held_x   <= cx;
                    r_held_y   <= cy;
                    r_held_ox  <= r_down_x;
                    r_held_oy  <= r_down_y;
                    r_held_dur <= dur;
                end
            end
        end
    end

    // An empty slot reads back with all position and time fields at zero.
    always_comb begin
        o_event    = r_held_type;
        o_pos_x    = '0;
        o_pos_y    = '0;
        o_origin_x = '0;
        o_origin_y = '0;
        o_duration = '0;
        if (r_held_type != EV_NONE) begin
            o_pos_x    = r_held_x;
            o_pos_y    = r_held_y;
            o_origin_x = r_held_ox;
            o_origin_y = r_held_oy;
            o_duration = r_held_dur;
        end
    end

endmodule

`default_nettype wire

[src/touch_gesture_classifier.sv]
// Touch gesture classifier.
// Input items arrive on the s_axis channel. tuser selects the operation: an
// update tick carries time, interrupt level, touch flag and raw coordinates
// in tdata; a pop request asks for the held gesture item. Update ticks give
// no output; each pop gives exactly one item on the m_axis channel, with the
// gesture code in tuser and the positions and duration in tdata.
// An accepted item is held in the input register and evaluated from there by
// a single pass of compare and subtract logic; a pop result is loaded into
// the output register, which drives m_axis_tvalid. One item is accepted
// per cycle when the output side keeps up. If the receiver stalls with a
// result waiting, update items keep flowing; a pop waits in the input
// register until the output register frees, and s_axis_tready stays low
// meanwhile.
// Configuration writes on the cfg channel are always ready and take effect
// the next cycle; write them only while the block is idle.
// Synchronous active-low reset restores register defaults, clears the
// pressed state, the held gesture and the poll and interrupt timestamps.
`default_nettype none

module touch_gesture_classifier
    import tgc_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
    localparam int XW = $clog2(SCREEN_WIDTH),
    localparam int YW = $clog2(SCREEN_HEIGHT),
    localparam int OUT_BITS = 2 * XW + 2 * YW + TIME_W,
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // now_ms, int_low, touching, raw_x, raw_y
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // operation
    input  wire logic [0:0]            s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // pos_x, pos_y, origin_x, origin_y, duration_ms
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // event_type
    output logic [EV_W-1:0]            m_axis_tuser,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg                  cfg;
    logic                  r_in_valid, r_out_valid;
    t_op                   r_in_op;
    logic [IN_BITS-1:0]    r_in_data;
    logic                  fire, out_free, s_accept;
    t_event                ev;
    logic [XW-1:0]         pos_x, origin_x;
    logic [YW-1:0]         pos_y, origin_y;
    logic [TIME_W-1:0]     duration;
    t_event                r_out_ev;
    logic [OUT_BITS-1:0]   r_out_data;

    assign o_cfg_ready = 1'b1;

    tgc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Updates always proceed; a pop needs room in the output register.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && ((r_in_op == OP_UPDATE) || out_free);
    assign s_axis_tready = !r_in_valid || fire;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_op   <= t_op'(s_axis_tuser[0]);
            r_in_data <= s_axis_tdata[IN_BITS-1:0];
        end
    end

    tgc_core #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_op       (r_in_op),
        .i_now      (r_in_data[TIME_W-1:0]),
        .i_int_low  (r_in_data[TIME_W]),
        .i_touching (r_in_data[TIME_W+1]),
        .i_raw_x    (r_in_data[TIME_W+2 +: RAW_W]),
        .i_raw_y    (r_in_data[TIME_W+2+RAW_W +: RAW_W]),
        .i_cfg      (cfg),
        .o_event    (ev),
        .o_pos_x    (pos_x),
        .o_pos_y    (pos_y),
        .o_origin_x (origin_x),
        .o_origin_y (origin_y),
        .o_duration (duration)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && r_in_op == OP_POP) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && r_in_op == OP_POP) begin
            r_out_ev   <= ev;
            r_out_data <= {duration, origin_y, origin_x, pos_y, pos_x};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_ev;
    assign m_axis_tdata  = OUT_DATA_W'(r_out_data);

endmodule

`default_nettype wire
